[rtl/pat_pkg.sv]
// Package: request/response types, kind codes and register offsets for the timer.
`timescale 1ns / 1ps

package pat_pkg;

  localparam int unsigned CounterWidthDef   = 32;
  localparam int unsigned TickCountWidthDef = 16;

  // request kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // register byte offsets
  localparam logic [7:0] OFS_CONTROL    = 8'h00;
  localparam logic [7:0] OFS_IRQ_ENABLE = 8'h0C;
  localparam logic [7:0] OFS_STATUS     = 8'h10;
  localparam logic [7:0] OFS_COUNTER    = 8'h24;
  localparam logic [7:0] OFS_PRESCALER  = 8'h28;
  localparam logic [7:0] OFS_RELOAD     = 8'h2C;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  reg_offset;
    logic [31:0] write_data;
    logic [15:0] tick_count;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        access_error;
    logic        irq_request;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_TICK = 3'b010,
    S_DONE = 3'b100
  } state_e;

endpackage

[rtl/prescaled_autoreload_timer.sv]
// Prescaled auto-reload timer: register file, tick sequencer and response register.
`timescale 1ns / 1ps

// Response: a read, a write, or a burst that does nothing (zero ticks or counting off) shows
//   its response in the cycle after the request is taken; a burst runs S_TICK, then S_DONE.
// Throughput: one access per cycle while the output is not stalled; a burst stalls the request
//   side until S_DONE responds, as one tick unit (prescale and counter compare/increment) runs once a cycle.
// Reset: rst_ni clears all registers but the response data out_q asynchronously; no clearing pass is needed.
module prescaled_autoreload_timer #(
  parameter int unsigned COUNTER_WIDTH    = pat_pkg::CounterWidthDef,
  parameter int unsigned TICK_COUNT_WIDTH = pat_pkg::TickCountWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pat_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pat_pkg::rsp_t out_rsp_o
);

  localparam int unsigned CW = COUNTER_WIDTH;
  localparam int unsigned TW = TICK_COUNT_WIDTH;

  // architectural registers
  logic          en_q, en_d;
  logic          ie_q, ie_d;
  logic          flag_q, flag_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] psc_q, psc_d;
  logic [CW-1:0] arr_q, arr_d;
  logic [CW-1:0] prog_q, prog_d;

  // sequencer
  pat_pkg::state_e state_q, state_d;
  logic [TW-1:0]   remain_q, remain_d;
  logic            irq_acc_q, irq_acc_d;

  // response register
  logic          out_valid_q, out_valid_d;
  pat_pkg::rsp_t out_q, out_d;

  logic          out_free;
  logic          accept;
  logic [TW+15:0] ticks_ext;
  logic [TW-1:0]  ticks_in;
  logic [CW-1:0]  wr_val;
  logic [CW+31:0] rd_ext;
  logic [31:0]    rd_val;
  logic           rd_ok;
  logic [CW-1:0]  rd_raw;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != pat_pkg::S_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  // tick count sized to TW bits, zero-extended or truncated
  assign ticks_ext = {{TW{1'b0}}, in_req_i.tick_count};
  assign ticks_in  = ticks_ext[TW-1:0];
  assign wr_val    = in_req_i.write_data[CW-1:0];

  // register read mux
  always_comb begin
    rd_ok  = 1'b1;
    rd_raw = '0;
    case (in_req_i.reg_offset)
      pat_pkg::OFS_CONTROL:    rd_raw = CW'(en_q);
      pat_pkg::OFS_IRQ_ENABLE: rd_raw = CW'(ie_q);
      pat_pkg::OFS_STATUS:     rd_raw = CW'(flag_q);
      pat_pkg::OFS_COUNTER:    rd_raw = cnt_q;
      pat_pkg::OFS_PRESCALER:  rd_raw = psc_q;
      pat_pkg::OFS_RELOAD:     rd_raw = arr_q;
      default:                 rd_ok  = 1'b0;
    endcase
  end

  assign rd_ext = {32'd0, rd_raw};
  assign rd_val = rd_ext[31:0];

  always_comb begin
    en_d        = en_q;
    ie_d        = ie_q;
    flag_d      = flag_q;
    cnt_d       = cnt_q;
    psc_d       = psc_q;
    arr_d       = arr_q;
    prog_d      = prog_q;
    state_d     = state_q;
    remain_d    = remain_q;
    irq_acc_d   = irq_acc_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    case (state_q)
      pat_pkg::S_IDLE: begin
        if (accept) begin
          out_d = '0;
          case (in_req_i.kind)
            pat_pkg::KIND_READ: begin
              out_valid_d        = 1'b1;
              out_d.read_data    = rd_ok ? rd_val : 32'd0;
              out_d.access_error = !rd_ok;
            end
            pat_pkg::KIND_WRITE: begin
              out_valid_d = 1'b1;
              case (in_req_i.reg_offset)
                pat_pkg::OFS_CONTROL:    en_d   = in_req_i.write_data[0];
                pat_pkg::OFS_IRQ_ENABLE: ie_d   = in_req_i.write_data[0];
                pat_pkg::OFS_STATUS:     flag_d = in_req_i.write_data[0];
                pat_pkg::OFS_COUNTER:    cnt_d  = wr_val;
                pat_pkg::OFS_PRESCALER: begin
                  psc_d  = wr_val;
                  prog_d = '0;
                end
                pat_pkg::OFS_RELOAD:     arr_d  = wr_val;
                default:                 out_d.access_error = 1'b1;
              endcase
            end
            pat_pkg::KIND_TICK: begin
              if (en_q && (ticks_in != '0)) begin
                state_d   = pat_pkg::S_TICK;
                remain_d  = ticks_in;
                irq_acc_d = 1'b0;
              end else begin
                out_valid_d = 1'b1;
              end
            end
            default: out_valid_d = 1'b1;  // reserved kind: empty response
          endcase
        end
      end

      // one tick per cycle through the compare/increment unit
      pat_pkg::S_TICK: begin
        if (prog_q < psc_q) begin
          prog_d = prog_q + 1'b1;
        end else begin
          prog_d = '0;
          if (cnt_q >= arr_q) begin
            cnt_d     = '0;
            flag_d    = 1'b1;
            irq_acc_d = irq_acc_q | ie_q;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        remain_d = remain_q - 1'b1;
        if (remain_q == TW'(1)) begin
          state_d = pat_pkg::S_DONE;
        end
      end

      pat_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d             = '0;
          out_d.irq_request = irq_acc_q;
          state_d           = pat_pkg::S_IDLE;
        end
      end

      default: state_d = pat_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q        <= 1'b0;
      ie_q        <= 1'b0;
      flag_q      <= 1'b0;
      cnt_q       <= '0;
      psc_q       <= '0;
      arr_q       <= '0;
      prog_q      <= '0;
      state_q     <= pat_pkg::S_IDLE;
      remain_q    <= '0;
      irq_acc_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      en_q        <= en_d;
      ie_q        <= ie_d;
      flag_q      <= flag_d;
      cnt_q       <= cnt_d;
      psc_q       <= psc_d;
      arr_q       <= arr_d;
      prog_q      <= prog_d;
      state_q     <= state_d;
      remain_q    <= remain_d;
      irq_acc_q   <= irq_acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // prescale progress never passes the prescaler: a prescaler write clears it
  a_prog_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prog_q <= psc_q)
    else $error("prescale progress above prescaler");

  // a burst only runs while counting is enabled and ticks remain
  a_tick_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pat_pkg::S_TICK) |-> (en_q && (remain_q != '0)))
    else $error("tick state with counting off or no ticks left");

  // a pending interrupt implies an update happened with the interrupt enabled
  a_irq_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q != pat_pkg::S_IDLE) && irq_acc_q) |-> (ie_q && flag_q))
    else $error("interrupt without enabled update");

  // requests are taken only in the idle state
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (state_q == pat_pkg::S_IDLE))
    else $error("request taken while busy");

  // the state register stays one-hot
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state not one-hot");

endmodule

[test/testbench.sv]
// Testbench: directed and random register/tick requests against a cycle-free timer predictor.
`timescale 1ns / 1ps

module testbench;
  import pat_pkg::*;

  // Kind 3 has no meaning; the block drops the request and answers all zeros.
  localparam logic [1:0] KIND_IGNORED = 2'd3;

  localparam int unsigned CW           = CounterWidthDef;
  localparam int          RANDOM_ITEMS = 600;
  // Short drain: an access answers in the cycle after it is taken.
  localparam int          DRAIN_CYCLES = 16;
  // Long bursts dominate: one 65535-tick directed burst plus a few random ones.
  localparam int          CYCLE_LIMIT  = 2_000_000;

  logic  clk_i = 1'b0;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_stall_o;
  req_t  in_req_i;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  rsp_t  out_rsp_o;

  always #4 clk_i = ~clk_i;

  prescaled_autoreload_timer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  // Directed row: the request, and a typed-in response where it is obvious.
  typedef struct {
    req_t req;
    bit   fixed;
    rsp_t rsp;
  } stim_row_t;

  stim_row_t directed_rows[$];
  rsp_t      due_responses[$];
  int        failures    = 0;
  int        cycle_count = 0;
  bit        calm        = 1'b0;  // no idling on either side while set

  // Timer state as the predictor sees it.
  bit          tm_enable;
  bit          tm_irq_en;
  bit          tm_flag;
  logic [CW-1:0] tm_counter;
  logic [CW-1:0] tm_prescale;
  logic [CW-1:0] tm_reload;
  logic [CW-1:0] tm_progress;

  function automatic bit reg_known(logic [7:0] ofs);
    case (ofs)
      OFS_CONTROL, OFS_IRQ_ENABLE, OFS_STATUS,
      OFS_COUNTER, OFS_PRESCALER, OFS_RELOAD: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Applies one request to the predicted timer state and returns its response.
  function automatic rsp_t timer_step(req_t r);
    rsp_t rsp;
    int   i;
    rsp = '0;
    case (r.kind)
      KIND_READ: begin
        rsp.access_error = !reg_known(r.reg_offset);
        case (r.reg_offset)
          OFS_CONTROL:    rsp.read_data = 32'(tm_enable);
          OFS_IRQ_ENABLE: rsp.read_data = 32'(tm_irq_en);
          OFS_STATUS:     rsp.read_data = 32'(tm_flag);
          OFS_COUNTER:    rsp.read_data = 32'(tm_counter);
          OFS_PRESCALER:  rsp.read_data = 32'(tm_prescale);
          OFS_RELOAD:     rsp.read_data = 32'(tm_reload);
          default:        rsp.read_data = '0;
        endcase
      end
      KIND_WRITE: begin
        rsp.access_error = !reg_known(r.reg_offset);
        case (r.reg_offset)
          OFS_CONTROL:    tm_enable = r.write_data[0];
          OFS_IRQ_ENABLE: tm_irq_en = r.write_data[0];
          OFS_STATUS:     tm_flag   = r.write_data[0];  // replaces, may set
          OFS_COUNTER:    tm_counter = r.write_data[CW-1:0];
          OFS_PRESCALER: begin
            tm_prescale = r.write_data[CW-1:0];
            tm_progress = '0;
          end
          OFS_RELOAD:     tm_reload = r.write_data[CW-1:0];
          default: ;
        endcase
      end
      KIND_TICK: begin
        // counting off: the whole burst is a no-op
        if (tm_enable) begin
          for (i = 0; i < int'(r.tick_count); i++) begin
            if (tm_progress < tm_prescale) begin
              tm_progress = tm_progress + 1'b1;
            end else begin
              tm_progress = '0;
              if (tm_counter >= tm_reload) begin
                tm_counter = '0;
                tm_flag    = 1'b1;
                if (tm_irq_en) rsp.irq_request = 1'b1;
              end else begin
                tm_counter = tm_counter + 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic void add_row(logic [1:0] kind, logic [7:0] ofs, logic [31:0] data,
                                  logic [15:0] ticks, bit fixed, logic [31:0] rd = '0,
                                  bit err = 1'b0, bit irq = 1'b0);
    stim_row_t row;
    row.req   = '{kind: kind, reg_offset: ofs, write_data: data, tick_count: ticks};
    row.fixed = fixed;
    row.rsp   = '{read_data: rd, access_error: err, irq_request: irq};
    directed_rows.push_back(row);
  endfunction

  // Random request. Kind starts as tick; offset, data and tick count start random
  // (the ignored ones stay that way), then the mix is steered toward enabled
  // counting with small prescaler and reload so wraps and interrupts happen often.
  function automatic req_t random_request();
    req_t r;
    int   sel;
    int   pick;
    r.kind       = KIND_TICK;
    r.reg_offset = 8'($urandom_range(0, 255));
    r.write_data = $urandom();
    r.tick_count = 16'($urandom_range(0, 65535));
    sel = $urandom_range(0, 99);
    if (sel < 38) begin
      pick = $urandom_range(0, 99);
      if (pick < 5)       r.tick_count = '0;
      else if (pick < 97) r.tick_count = 16'($urandom_range(1, 24));
      else if (pick < 99) r.tick_count = 16'($urandom_range(25, 300));
      else                r.tick_count = 16'($urandom_range(1024, 65535));
    end else if (sel < 84) begin
      r.kind = (sel < 60) ? KIND_READ : KIND_WRITE;
      case ($urandom_range(0, 5))
        0: r.reg_offset = OFS_CONTROL;
        1: r.reg_offset = OFS_IRQ_ENABLE;
        2: r.reg_offset = OFS_STATUS;
        3: r.reg_offset = OFS_COUNTER;
        4: r.reg_offset = OFS_PRESCALER;
        default: r.reg_offset = OFS_RELOAD;
      endcase
      if ($urandom_range(0, 99) < 80) begin
        case (r.reg_offset)
          OFS_CONTROL, OFS_IRQ_ENABLE:
            r.write_data[0] = ($urandom_range(0, 3) != 0);  // mostly on
          OFS_COUNTER:   r.write_data = $urandom_range(0, 14);
          OFS_PRESCALER: r.write_data = $urandom_range(0, 3);
          OFS_RELOAD:    r.write_data = $urandom_range(0, 12);
          default: ;
        endcase
      end
    end else if (sel < 92) begin
      r.kind = $urandom_range(0, 1) ? KIND_WRITE : KIND_READ;
      while (reg_known(r.reg_offset)) r.reg_offset = 8'($urandom_range(0, 255));
    end else if (sel < 96) begin
      r.kind = KIND_IGNORED;
    end else begin
      r.tick_count = 16'($urandom_range(0, 3));
    end
    return r;
  endfunction

  // Drives one request and holds it until taken; the prediction is made at acceptance.
  task automatic issue(req_t r, bit fixed, rsp_t fixed_rsp);
    rsp_t predicted;
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = timer_step(r);
    due_responses.push_back(fixed ? fixed_rsp : predicted);
  endtask

  // Random sender gap before the next request.
  task automatic sender_gap();
    if (!calm && $urandom_range(0, 99) < 30) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // Receiver stalls at random, except during the calm stretch.
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 36);
  end

  // Response check: in order, field by field.
  always @(posedge clk_i) begin : rsp_check
    rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_responses.size() == 0) begin
        $error("response with no request outstanding: %p", out_rsp_o);
        failures++;
      end else begin
        want = due_responses.pop_front();
        if (out_rsp_o.read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, out_rsp_o.read_data);
          failures++;
        end
        if (out_rsp_o.access_error !== want.access_error) begin
          $error("access_error: expected %b, got %b", want.access_error,
                 out_rsp_o.access_error);
          failures++;
        end
        if (out_rsp_o.irq_request !== want.irq_request) begin
          $error("irq_request: expected %b, got %b", want.irq_request,
                 out_rsp_o.irq_request);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d responses outstanding", cycle_count,
             due_responses.size());
      $display("prescaled_autoreload_timer regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    req_t r;
    int   n;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    tm_enable   = 1'b0;
    tm_irq_en   = 1'b0;
    tm_flag     = 1'b0;
    tm_counter  = '0;
    tm_prescale = '0;
    tm_reload   = '0;
    tm_progress = '0;

    // Reset values, unknown offsets, counting off.
    add_row(KIND_READ,  OFS_CONTROL,    '0, '0, 1'b1);
    add_row(KIND_READ,  OFS_IRQ_ENABLE, '0, '0, 1'b1);
    add_row(KIND_READ,  OFS_STATUS,     '0, '0, 1'b1);
    add_row(KIND_READ,  OFS_COUNTER,    '0, '0, 1'b1);
    add_row(KIND_READ,  OFS_PRESCALER,  '0, '0, 1'b1);
    add_row(KIND_READ,  OFS_RELOAD,     '0, '0, 1'b1);
    add_row(KIND_READ,  8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, '0, 1'b1);
    add_row(KIND_WRITE, 8'h04, 32'hFFFF_FFFF, '0, 1'b1, '0, 1'b1);
    add_row(KIND_TICK,  8'hFF, 32'hFFFF_FFFF, 16'd5, 1'b1);
    // Extremes: prescaler and reload at maximum, counter one below.
    add_row(KIND_WRITE, OFS_PRESCALER, 32'hFFFF_FFFF, '0, 1'b1);
    add_row(KIND_READ,  OFS_PRESCALER, '0, '0, 1'b1, 32'hFFFF_FFFF);
    add_row(KIND_WRITE, OFS_RELOAD,    32'hFFFF_FFFF, '0, 1'b1);
    add_row(KIND_WRITE, OFS_COUNTER,   32'hFFFF_FFFE, '0, 1'b1);
    add_row(KIND_WRITE, OFS_CONTROL,   32'hFFFF_FFFF, '0, 1'b1);
    // upper control bits are dropped
    add_row(KIND_READ,  OFS_CONTROL,   '0, '0, 1'b1, 32'd1);
    // longest burst, prescale never reached
    add_row(KIND_TICK,  '0, '0, 16'hFFFF, 1'b0);
    // prescaler write also clears the prescale progress
    add_row(KIND_WRITE, OFS_PRESCALER, '0, '0, 1'b1);
    add_row(KIND_WRITE, OFS_IRQ_ENABLE, 32'd1, '0, 1'b1);
    // counter steps to max, then wraps with the interrupt enabled
    add_row(KIND_TICK,  '0, '0, 16'd3, 1'b0);
    add_row(KIND_READ,  OFS_STATUS,  '0, '0, 1'b0);
    // status write replaces the flag: clear, then set it by a write
    add_row(KIND_WRITE, OFS_STATUS,  '0, '0, 1'b1);
    add_row(KIND_READ,  OFS_STATUS,  '0, '0, 1'b1);
    add_row(KIND_WRITE, OFS_STATUS,  32'hFFFF_FFFF, '0, 1'b1);
    add_row(KIND_READ,  OFS_COUNTER, '0, '0, 1'b0);
    // zero ticks, then the ignored kind
    add_row(KIND_TICK,  '0, '0, '0, 1'b1);
    add_row(KIND_IGNORED, 8'hA5, 32'h5A5A_A5A5, 16'hFFFF, 1'b1);
    add_row(KIND_WRITE, OFS_RELOAD, 32'd2, '0, 1'b1);
    add_row(KIND_TICK,  '0, '0, 16'd9, 1'b0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k]) begin
      sender_gap();
      issue(directed_rows[k].req, directed_rows[k].fixed, directed_rows[k].rsp);
    end

    // Random part; ignored kinds do not count toward the total.
    n = 0;
    while (n < RANDOM_ITEMS) begin
      r = random_request();
      if (r.kind != KIND_IGNORED) n++;
      calm <= (n >= 220 && n < 340);
      sender_gap();
      issue(r, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (due_responses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("prescaled_autoreload_timer regression: pass");
    end else begin
      $display("prescaled_autoreload_timer regression: fail");
    end
    $finish;
  end

endmodule
